[src/ndrr_pkg.sv]
// shared types and constants for the debris proximity block
package ndrr_pkg;

    localparam int DEF_MAX_ENTRIES  = 1024;
    localparam int DEF_KEEP_CLOSEST = 10;

    localparam int POS_W   = 25;
    localparam int ID_W    = 16;
    localparam int DIST_W  = 52;
    localparam int CNT_W   = 11;
    localparam int RISK_W  = 3;
    localparam int RANK_W  = 4;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] COUNT_SAT = 11'd2047;
    localparam logic [DIST_W-1:0] UNSET_MAG_SQ = 52'd656;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SPARE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_NEAR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CROWD = 2'd3;

    localparam logic [RISK_W-1:0] RISK_NONE = 3'd0;
    localparam logic [RISK_W-1:0] RISK_LOW  = 3'd1;
    localparam logic [RISK_W-1:0] RISK_MED  = 3'd2;
    localparam logic [RISK_W-1:0] RISK_HIGH = 3'd3;
    localparam logic [RISK_W-1:0] RISK_CRIT = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic clear;
        logic append;
        logic start;     // latch query, reset list
        logic rd;        // issue memory read of scan index
        logic proc;      // process returned entry
        logic rate;      // compute risk
        logic emit;      // load output register
    } ndrr_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic scan_done;
        logic drain_done;
    } ndrr_sts_t;

endpackage

[src/nearest_debris_risk_rating.sv]
// top level of the debris proximity and risk block
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_stall   | command, object_id, craft_id, pos_x/y/z
//  out     | output    | out_valid/out_stall | sat_tag .. last
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
// append and clear do not stall the input; after its beat a query keeps the input stalled
// while it scans the N stored entries one read a cycle, drains the distance pipeline,
// rates the risk, sends K result beats (at least one) and ends.
// reset empties the table and restores register defaults; no clearing pass.
// a stalled result holds, and result stalls lengthen the query.
module nearest_debris_risk_rating #(
    parameter int MAX_ENTRIES  = ndrr_pkg::DEF_MAX_ENTRIES,
    parameter int KEEP_CLOSEST = ndrr_pkg::DEF_KEEP_CLOSEST
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          command,
    input  logic [15:0]         object_id,
    input  logic [15:0]         craft_id,
    input  logic signed [24:0]  pos_x,
    input  logic signed [24:0]  pos_y,
    input  logic signed [24:0]  pos_z,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [15:0]         sat_tag,
    output logic [3:0]          rank,
    output logic                entry_valid,
    output logic [15:0]         near_id,
    output logic [51:0]         dist_sq,
    output logic [10:0]         near_count,
    output logic [2:0]          risk,
    output logic                last,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [51:0]         cfg_data
);
    import ndrr_pkg::*;

    ndrr_cmd_t cmd;
    ndrr_sts_t sts;
    logic [51:0] near_reg, crit_reg, high_reg;
    logic [10:0] crowd_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg  <= 52'd655360000;
            crit_reg  <= 52'd65536;
            high_reg  <= 52'd6553600;
            crowd_reg <= 11'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NEAR:  near_reg  <= cfg_data;
                REG_CRIT:  crit_reg  <= cfg_data;
                REG_HIGH:  high_reg  <= cfg_data;
                REG_CROWD: crowd_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    ndrr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    ndrr_datapath #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .KEEP_CLOSEST (KEEP_CLOSEST)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .object_id         (object_id),
        .craft_id          (craft_id),
        .pos_x             (pos_x),
        .pos_y             (pos_y),
        .pos_z             (pos_z),
        .near_range_sq     (near_reg),
        .critical_range_sq (crit_reg),
        .high_range_sq     (high_reg),
        .crowd_limit       (crowd_reg),
        .sat_tag           (sat_tag),
        .rank              (rank),
        .entry_valid       (entry_valid),
        .near_id           (near_id),
        .dist_sq           (dist_sq),
        .near_count        (near_count),
        .risk              (risk),
        .last              (last)
    );

endmodule

[src/ndrr_datapath.sv]
// table memory, distance pipeline, sorted list and result register
module ndrr_datapath #(
    parameter int MAX_ENTRIES  = ndrr_pkg::DEF_MAX_ENTRIES,
    parameter int KEEP_CLOSEST = ndrr_pkg::DEF_KEEP_CLOSEST
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ndrr_pkg::ndrr_cmd_t           cmd,
    output ndrr_pkg::ndrr_sts_t           sts,
    input  logic [15:0]                   object_id,
    input  logic [15:0]                   craft_id,
    input  logic signed [24:0]            pos_x,
    input  logic signed [24:0]            pos_y,
    input  logic signed [24:0]            pos_z,
    input  logic [51:0]                   near_range_sq,
    input  logic [51:0]                   critical_range_sq,
    input  logic [51:0]                   high_range_sq,
    input  logic [10:0]                   crowd_limit,
    output logic [15:0]                   sat_tag,
    output logic [3:0]                    rank,
    output logic                          entry_valid,
    output logic [15:0]                   near_id,
    output logic [51:0]                   dist_sq,
    output logic [10:0]                   near_count,
    output logic [2:0]                    risk,
    output logic                          last
);
    import ndrr_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int KW = $clog2(KEEP_CLOSEST + 1);

    // table storage
    logic [ID_W-1:0]  mem_id  [MAX_ENTRIES];
    logic [POS_W-1:0] mem_x   [MAX_ENTRIES];
    logic [POS_W-1:0] mem_y   [MAX_ENTRIES];
    logic [POS_W-1:0] mem_z   [MAX_ENTRIES];

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_reg;
    logic [ID_W-1:0] rd_id_reg;
    logic signed [POS_W-1:0] rd_x_reg, rd_y_reg, rd_z_reg;

    // fill count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
            count_next = '0;
        else if (cmd.append && count_reg < CW'(MAX_ENTRIES))
            count_next = count_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.append && count_reg < CW'(MAX_ENTRIES))
        begin
            mem_id[count_reg[AW-1:0]] <= object_id;
            mem_x[count_reg[AW-1:0]]  <= pos_x;
            mem_y[count_reg[AW-1:0]]  <= pos_y;
            mem_z[count_reg[AW-1:0]]  <= pos_z;
        end
        if (cmd.rd)
        begin
            rd_id_reg <= mem_id[scan_reg[AW-1:0]];
            rd_x_reg  <= mem_x[scan_reg[AW-1:0]];
            rd_y_reg  <= mem_y[scan_reg[AW-1:0]];
            rd_z_reg  <= mem_z[scan_reg[AW-1:0]];
        end
    end

    // scan index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_reg <= '0;
        else if (cmd.start)
            scan_reg <= '0;
        else if (cmd.rd)
            scan_reg <= scan_reg + CW'(1);
    end

    // query position
    logic signed [POS_W-1:0] qx_reg, qy_reg, qz_reg;
    logic [ID_W-1:0] tag_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            qx_reg  <= pos_x;
            qy_reg  <= pos_y;
            qz_reg  <= pos_z;
            tag_reg <= craft_id;
        end
    end

    // stage one: differences
    logic signed [POS_W:0] dx, dy, dz;
    assign dx = {rd_x_reg[POS_W-1], rd_x_reg} - {qx_reg[POS_W-1], qx_reg};
    assign dy = {rd_y_reg[POS_W-1], rd_y_reg} - {qy_reg[POS_W-1], qy_reg};
    assign dz = {rd_z_reg[POS_W-1], rd_z_reg} - {qz_reg[POS_W-1], qz_reg};

    logic [POS_W-1:0] adx, ady, adz, amx, amy, amz;
    assign adx = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
    assign ady = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
    assign adz = dz[POS_W] ? POS_W'(-dz) : dz[POS_W-1:0];
    assign amx = rd_x_reg[POS_W-1] ? POS_W'(-rd_x_reg) : rd_x_reg;
    assign amy = rd_y_reg[POS_W-1] ? POS_W'(-rd_y_reg) : rd_y_reg;
    assign amz = rd_z_reg[POS_W-1] ? POS_W'(-rd_z_reg) : rd_z_reg;

    // stage two: squares, registered
    logic [2*POS_W-1:0] sx_reg, sy_reg, sz_reg, mx_reg, my_reg, mz_reg;
    logic [ID_W-1:0] p_id_reg;
    logic p_vld_reg;
    always_ff @(posedge clk)
    begin
        sx_reg <= adx * adx;
        sy_reg <= ady * ady;
        sz_reg <= adz * adz;
        mx_reg <= amx * amx;
        my_reg <= amy * amy;
        mz_reg <= amz * amz;
        p_id_reg <= rd_id_reg;
    end

    // process strobe delayed to line up with squares
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_vld_reg <= 1'b0;
        else
            p_vld_reg <= cmd.proc;
    end

    // stage three: sums and compares
    logic [DIST_W-1:0] d, mag;
    assign d   = DIST_W'(sx_reg) + DIST_W'(sy_reg) + DIST_W'(sz_reg);
    assign mag = DIST_W'(mx_reg) + DIST_W'(my_reg) + DIST_W'(mz_reg);

    logic [DIST_W-1:0] e_d_reg;
    logic [ID_W-1:0]   e_id_reg;
    logic              e_vld_reg;
    always_ff @(posedge clk)
    begin
        e_d_reg  <= d;
        e_id_reg <= p_id_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else
            e_vld_reg <= p_vld_reg && !(mag < UNSET_MAG_SQ) && (d < near_range_sq);
    end

    // sorted closest list, insertion by shifting
    logic [DIST_W-1:0] kd_reg [KEEP_CLOSEST];
    logic [ID_W-1:0]   kid_reg [KEEP_CLOSEST];
    logic [KW-1:0]     kept_reg;
    logic [CNT_W-1:0]  near_reg;
    logic [KEEP_CLOSEST-1:0] gt;

    always_comb
    begin
        for (int k = 0; k < KEEP_CLOSEST; k++)
            gt[k] = (KW'(k) < kept_reg) && (kd_reg[k] > e_d_reg);
    end

    always_ff @(posedge clk)
    begin
        if (e_vld_reg)
        begin
            for (int k = 0; k < KEEP_CLOSEST; k++)
            begin
                if (gt[k])
                begin
                    if (k == 0 || !gt[(k == 0) ? 0 : k-1])
                    begin
                        kd_reg[k]  <= e_d_reg;
                        kid_reg[k] <= e_id_reg;
                    end
                    else
                    begin
                        kd_reg[k]  <= kd_reg[(k == 0) ? 0 : k-1];
                        kid_reg[k] <= kid_reg[(k == 0) ? 0 : k-1];
                    end
                end
                else if (KW'(k) == kept_reg)
                begin
                    if (k == 0 || !gt[(k == 0) ? 0 : k-1])
                    begin
                        kd_reg[k]  <= e_d_reg;
                        kid_reg[k] <= e_id_reg;
                    end
                    else
                    begin
                        kd_reg[k]  <= kd_reg[(k == 0) ? 0 : k-1];
                        kid_reg[k] <= kid_reg[(k == 0) ? 0 : k-1];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_reg <= '0;
            near_reg <= '0;
        end
        else if (cmd.start)
        begin
            kept_reg <= '0;
            near_reg <= '0;
        end
        else if (e_vld_reg)
        begin
            if (near_reg != COUNT_SAT)
                near_reg <= near_reg + CNT_W'(1);
            if (kept_reg < KW'(KEEP_CLOSEST))
                kept_reg <= kept_reg + KW'(1);
        end
    end

    // risk rating
    logic [RISK_W-1:0] risk_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.rate)
        begin
            if (kept_reg != '0 && kd_reg[0] < critical_range_sq)
                risk_reg <= RISK_CRIT;
            else if (kept_reg != '0 && kd_reg[0] < high_range_sq)
                risk_reg <= RISK_HIGH;
            else if (near_reg > crowd_limit)
                risk_reg <= RISK_MED;
            else if (near_reg != '0)
                risk_reg <= RISK_LOW;
            else
                risk_reg <= RISK_NONE;
        end
    end

    // drain index and result register
    logic [KW-1:0] out_reg;
    logic [KW-1:0] last_idx;
    assign last_idx = (kept_reg == '0) ? '0 : kept_reg - KW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_reg <= '0;
        else if (cmd.start)
            out_reg <= '0;
        else if (cmd.emit)
            out_reg <= out_reg + KW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            sat_tag     <= tag_reg;
            rank        <= RANK_W'(out_reg);
            entry_valid <= (kept_reg != '0);
            near_id     <= (kept_reg != '0) ? kid_reg[out_reg] : '0;
            dist_sq     <= (kept_reg != '0) ? kd_reg[out_reg] : '0;
            near_count  <= near_reg;
            risk        <= risk_reg;
            last        <= (out_reg == last_idx);
        end
    end

    assign sts.scan_done  = (scan_reg >= count_reg);
    assign sts.drain_done = (out_reg >= last_idx);

endmodule

[src/ndrr_ctrl.sv]
// command decode and query sequencer
module ndrr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            command,
    output logic                  out_valid,
    input  logic                  out_stall,
    output ndrr_pkg::ndrr_cmd_t   cmd,
    input  ndrr_pkg::ndrr_sts_t   sts
);
    import ndrr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_FLUSH = 6'b000100,
        S_RATE  = 6'b001000,
        S_EMIT  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] flush_reg, flush_next;
    logic out_valid_reg, out_valid_next;
    logic in_acc;
    logic rd_d_reg;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        flush_next     = flush_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    cmd.clear  = (command == CMD_CLEAR);
                    cmd.append = (command == CMD_APPEND);
                    if (command == CMD_QUERY)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    flush_next = 3'd0;
                    state_next = S_FLUSH;
                end
                else
                    cmd.rd = 1'b1;
            end
            S_FLUSH:
            begin
                flush_next = flush_reg + 3'd1;
                if (flush_reg == 3'd3)
                    state_next = S_RATE;
            end
            S_RATE:
            begin
                cmd.rate   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = sts.drain_done ? S_OUT : S_EMIT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        if (state_reg == S_EMIT && out_valid_reg && !out_stall && !cmd.emit)
            out_valid_next = 1'b0;
        // process strobe is the read strobe delayed by one register
        cmd.proc = rd_d_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_d_reg <= 1'b0;
        else
            rd_d_reg <= cmd.rd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            flush_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[test/ndrr_checker.sv]
// result predictor and scoreboard for the debris proximity block
module ndrr_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [1:0]          command,
    input  logic [15:0]         object_id,
    input  logic [15:0]         craft_id,
    input  logic signed [24:0]  pos_x,
    input  logic signed [24:0]  pos_y,
    input  logic signed [24:0]  pos_z,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [15:0]         sat_tag,
    input  logic [3:0]          rank,
    input  logic                entry_valid,
    input  logic [15:0]         near_id,
    input  logic [51:0]         dist_sq,
    input  logic [10:0]         near_count,
    input  logic [2:0]          risk,
    input  logic                last,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [51:0]         cfg_data,
    output int                  fail_count,
    output int                  pending,
    output int                  result_total
);
    timeunit 1ns;
    timeprecision 1ps;
    import ndrr_pkg::*;

    typedef struct packed {
        logic [15:0] tag;
        logic [3:0]  rnk;
        logic        valid;
        logic [15:0] id;
        logic [51:0] dsq;
        logic [10:0] cnt;
        logic [2:0]  rating;
        logic        fin;
    } risk_beat_t;

    // local copy of table and registers
    logic [15:0]        tbl_id [DEF_MAX_ENTRIES];
    logic signed [24:0] tbl_x  [DEF_MAX_ENTRIES];
    logic signed [24:0] tbl_y  [DEF_MAX_ENTRIES];
    logic signed [24:0] tbl_z  [DEF_MAX_ENTRIES];
    int                 tbl_len;
    logic [51:0]        near_lim, crit_lim, high_lim;
    logic [10:0]        crowd_lim;
    risk_beat_t         expected_beats [$];

    function automatic logic [51:0] sq3(logic signed [24:0] ax, logic signed [24:0] ay,
                                        logic signed [24:0] az, logic signed [24:0] bx,
                                        logic signed [24:0] by, logic signed [24:0] bz);
        longint dx, dy, dz;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        dz = longint'(az) - longint'(bz);
        return 52'(dx * dx + dy * dy + dz * dz);
    endfunction

    // scan the table for a query and queue its result beats
    task automatic rate_query(logic [15:0] tag, logic signed [24:0] qx,
                              logic signed [24:0] qy, logic signed [24:0] qz);
        logic [51:0] kd [DEF_KEEP_CLOSEST];
        logic [15:0] kid [DEF_KEEP_CLOSEST];
        int kept, cnt, pos, j;
        logic [51:0] d;
        logic [2:0] rt;
        risk_beat_t b;
        kept = 0;
        cnt = 0;
        for (int i = 0; i < tbl_len; i++)
        begin
            if (sq3(tbl_x[i], tbl_y[i], tbl_z[i], 0, 0, 0) < UNSET_MAG_SQ)
                continue;
            d = sq3(tbl_x[i], tbl_y[i], tbl_z[i], qx, qy, qz);
            if (!(d < near_lim))
                continue;
            if (cnt < 2047)
                cnt++;
            // ties stay in table order
            pos = kept;
            while (pos > 0 && kd[pos-1] > d)
                pos--;
            if (pos >= DEF_KEEP_CLOSEST)
                continue;
            j = (kept < DEF_KEEP_CLOSEST) ? kept : DEF_KEEP_CLOSEST - 1;
            while (j > pos)
            begin
                kd[j] = kd[j-1];
                kid[j] = kid[j-1];
                j--;
            end
            kd[pos] = d;
            kid[pos] = tbl_id[i];
            if (kept < DEF_KEEP_CLOSEST)
                kept++;
        end
        if (kept > 0 && kd[0] < crit_lim)
            rt = RISK_CRIT;
        else if (kept > 0 && kd[0] < high_lim)
            rt = RISK_HIGH;
        else if (cnt > crowd_lim)
            rt = RISK_MED;
        else if (cnt > 0)
            rt = RISK_LOW;
        else
            rt = RISK_NONE;
        if (kept == 0)
        begin
            b = '{tag, 4'd0, 1'b0, 16'd0, 52'd0, 11'(cnt), rt, 1'b1};
            expected_beats.insert(expected_beats.size(), b);
        end
        for (int i = 0; i < kept; i++)
        begin
            b = '{tag, 4'(i), 1'b1, kid[i], kd[i], 11'(cnt), rt, 1'(i == kept - 1)};
            expected_beats.insert(expected_beats.size(), b);
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        result_total = 0;
        pending = 0;
        tbl_len = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        risk_beat_t w;
        if (!rst_n)
        begin
            tbl_len = 0;
            near_lim = 52'd655360000;
            crit_lim = 52'd65536;
            high_lim = 52'd6553600;
            crowd_lim = 11'd10;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NEAR:  near_lim = cfg_data;
                    REG_CRIT:  crit_lim = cfg_data;
                    REG_HIGH:  high_lim = cfg_data;
                    REG_CROWD: crowd_lim = cfg_data[10:0];
                    default: ;
                endcase
            end
            // input beat
            if (in_valid && !in_stall)
            begin
                case (command)
                    CMD_CLEAR: tbl_len = 0;
                    CMD_APPEND:
                        if (tbl_len < DEF_MAX_ENTRIES)
                        begin
                            tbl_id[tbl_len] = object_id;
                            tbl_x[tbl_len] = pos_x;
                            tbl_y[tbl_len] = pos_y;
                            tbl_z[tbl_len] = pos_z;
                            tbl_len++;
                        end
                    CMD_QUERY: rate_query(craft_id, pos_x, pos_y, pos_z);
                    default: ;
                endcase
            end
            // result beat
            if (out_valid && !out_stall)
            begin
                result_total++;
                if (expected_beats.size() == 0)
                    report_mismatch("unexpected beat, sat_tag", sat_tag, 0);
                else
                begin
                    w = expected_beats.pop_front();
                    if (sat_tag !== w.tag) report_mismatch("sat_tag", sat_tag, w.tag);
                    if (rank !== w.rnk) report_mismatch("rank", rank, w.rnk);
                    if (entry_valid !== w.valid)
                        report_mismatch("entry_valid", entry_valid, w.valid);
                    if (near_id !== w.id) report_mismatch("near_id", near_id, w.id);
                    if (dist_sq !== w.dsq) report_mismatch("dist_sq", dist_sq, w.dsq);
                    if (near_count !== w.cnt)
                        report_mismatch("near_count", near_count, w.cnt);
                    if (risk !== w.rating) report_mismatch("risk", risk, w.rating);
                    if (last !== w.fin) report_mismatch("last", last, w.fin);
                end
            end
        end
        pending = expected_beats.size();
    end
endmodule

[test/testbench.sv]
// stimulus and verdict for the debris proximity block
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ndrr_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         command = CMD_CLEAR;
    logic [15:0]        object_id = '0;
    logic [15:0]        craft_id = '0;
    logic signed [24:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [15:0]        sat_tag, near_id;
    logic [3:0]         rank;
    logic               entry_valid, last;
    logic [51:0]        dist_sq;
    logic [10:0]        near_count;
    logic [2:0]         risk;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = REG_NEAR;
    logic [51:0]        cfg_data = '0;
    int                 fail_count, pending, result_total;
    int                 items_sent = 0;
    int                 queries_sent = 0;
    bit                 calm = 1'b0;      // no idling on either side
    bit                 hold_off = 1'b0;  // receiver holds off for a long stretch

    always #2 clk = ~clk;

    nearest_debris_risk_rating dut (.*);
    ndrr_checker chk (.*);

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else if (calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 24);
    end

    // long hold-off counted in cycles
    initial
    begin
        wait (queries_sent > 60);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    // random coordinate, often near the centre so that entries come near
    function automatic logic signed [24:0] rand_coord(logic signed [24:0] centre);
        case ($urandom_range(9))
            0: return 25'($urandom);
            1: return -25'sd16777216;
            2: return 25'sd16777215;
            3: return 25'($urandom_range(40)) - 25'sd20;
            default: return centre + 25'($urandom_range(8000)) - 25'sd4000;
        endcase
    endfunction

    // one input beat, with random idle before it
    task automatic send_beat(logic [1:0] cmd, logic [15:0] did, logic [15:0] sid,
                             logic signed [24:0] x, logic signed [24:0] y,
                             logic signed [24:0] z);
        while (!calm && !hold_off && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        object_id <= did;
        craft_id <= sid;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (cmd == CMD_QUERY)
            queries_sent++;
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [51:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        logic signed [24:0] cx, cy, cz;
        int n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, unset positions, ties, unused code
        send_beat(CMD_QUERY, 0, 16'hFFFF, 0, 0, 0);
        send_beat(CMD_APPEND, 16'h0001, 0, 0, 0, 0);
        send_beat(CMD_APPEND, 16'h0002, 0, 25, 0, 0);
        send_beat(CMD_APPEND, 16'h0003, 0, 26, 0, 0);
        send_beat(CMD_APPEND, 16'h0004, 0, 15, 15, 15);
        send_beat(CMD_APPEND, 16'hFFFF, 0, -25'sd16777216, -25'sd16777216, -25'sd16777216);
        send_beat(CMD_APPEND, 16'h8000, 0, 25'sd16777215, 25'sd16777215, 25'sd16777215);
        send_beat(CMD_APPEND, 16'h0005, 0, 26, 0, 0);
        send_beat(CMD_APPEND, 16'h0006, 0, 300, -200, 100);
        send_beat(CMD_SPARE, 16'h1234, 16'h5678, 1, 2, 3);
        send_beat(CMD_QUERY, 0, 16'h0000, 0, 0, 0);
        send_beat(CMD_QUERY, 0, 16'hA5A5, 25'sd16777215, 25'sd16777215, 25'sd16777215);
        send_beat(CMD_QUERY, 0, 16'h5A5A, -25'sd16777216, -25'sd16777216,
                  -25'sd16777216);
        go_idle();
        // widest near range: every set entry near
        write_reg(REG_NEAR, 52'hF_FFFF_FFFF_FFFF);
        write_reg(REG_CRIT, 52'd0);
        write_reg(REG_HIGH, 52'd0);
        write_reg(REG_CROWD, 11'd0);
        send_beat(CMD_QUERY, 0, 16'h0101, 26, 0, 0);
        send_beat(CMD_QUERY, 0, 16'h0202, -25'sd16777216, 25'sd16777215, 0);
        go_idle();
        write_reg(REG_CROWD, 11'h7FF);
        write_reg(REG_CRIT, 52'hF_FFFF_FFFF_FFFF);
        send_beat(CMD_QUERY, 0, 16'h0303, 0, 0, 0);
        send_beat(CMD_CLEAR, 0, 0, 0, 0, 0);
        send_beat(CMD_QUERY, 0, 16'h0404, 0, 0, 0);
        go_idle();
        write_reg(REG_NEAR, 52'd0);
        send_beat(CMD_APPEND, 16'h0007, 0, 500, 500, 500);
        send_beat(CMD_QUERY, 0, 16'h0505, 500, 500, 500);
        go_idle();

        // random phases: append to a cluster and query near it, interleaved
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_NEAR, ph == 3 ? 52'hF_FFFF_FFFF_FFFF : 52'($urandom_range(900000000)));
            write_reg(REG_CRIT, 52'($urandom_range(2000000)));
            write_reg(REG_HIGH, 52'($urandom_range(40000000)));
            write_reg(REG_CROWD, 11'($urandom_range(ph == 0 ? 2047 : 12)));
            calm = (ph == 1);
            send_beat(CMD_CLEAR, 0, 0, 0, 0, 0);
            cx = 25'($urandom);
            cy = 25'($urandom);
            cz = 25'($urandom);
            for (int k = 0; k < 84; k++)
            begin
                n = $urandom_range(9);
                if (n < 6)
                    send_beat(CMD_APPEND, 16'($urandom), 16'($urandom),
                              rand_coord(cx), rand_coord(cy), rand_coord(cz));
                else if (n < 9)
                    send_beat(CMD_QUERY, 16'($urandom), 16'($urandom),
                              rand_coord(cx), rand_coord(cy), rand_coord(cz));
                else
                    send_beat(($urandom_range(3) == 0) ? CMD_CLEAR : CMD_SPARE,
                              16'($urandom), 16'($urandom),
                              25'($urandom), 25'($urandom), 25'($urandom));
            end
            go_idle();
        end

        $display("sent %0d beats including %0d queries, %0d result beats checked",
                 items_sent, queries_sent, result_total);
        $display("covered register extremes, unset entries, ties, spare codes and back-pressure");
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
